@@ rtl/assert_macros.svh @@
// assertion helpers used by the gauge core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define BG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// implication into the next cycle
`define BG_ASSERT_NEXT(lbl, pre, post, msg) \
  `BG_ASSERT(lbl, (pre) |=> (post), msg)

`endif

@@ rtl/bgli_pkg.sv @@
`default_nettype none

package bgli_pkg;

  // field and register widths
  localparam int CheckW   = 16;
  localparam int BlinkW   = 8;
  localparam int NumW     = 20;
  localparam int OffW     = 10;
  localparam int AdcW     = 8;
  localparam int IconW    = 3;
  localparam int LevelW   = 3;
  localparam int PctW     = 8;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 20;

  // serial arithmetic widths
  localparam int ProdW = AdcW + OffW;
  localparam int DivW  = NumW;
  localparam int DsrW  = AdcW + 1;

  // register reset values
  localparam logic [CheckW-1:0] CheckPeriodRst = 16'd3000;
  localparam logic [BlinkW-1:0] BlinkPeriodRst = 8'd25;
  localparam logic [NumW-1:0]   ScaleNumRst    = 20'd78688;
  localparam logic [OffW-1:0]   ScaleOffRst    = 10'd325;

  // icon and level codes
  localparam logic [IconW-1:0]  IconBlank = 3'd6;
  localparam logic [IconW-1:0]  IconLow   = 3'd5;
  localparam logic [IconW-1:0]  IconNone  = 3'd0;
  localparam logic [LevelW-1:0] LevelLow  = 3'd5;

  // level thresholds in percent
  localparam logic [PctW-1:0] Thr0 = 8'd80;
  localparam logic [PctW-1:0] Thr1 = 8'd60;
  localparam logic [PctW-1:0] Thr2 = 8'd40;
  localparam logic [PctW-1:0] Thr3 = 8'd20;
  localparam logic [PctW-1:0] Thr4 = 8'd5;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgCheckPeriod = 2'd0,
    CfgBlinkPeriod = 2'd1,
    CfgScaleNum    = 2'd2,
    CfgScaleOff    = 2'd3
  } cfg_idx_e;

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // percent to battery level, 0 full .. 5 low
  function automatic logic [LevelW-1:0] level_of(input logic [PctW-1:0] p);
    logic [LevelW-1:0] lv;
    if (p >= Thr0) begin
      lv = 3'd0;
    end else if (p >= Thr1) begin
      lv = 3'd1;
    end else if (p >= Thr2) begin
      lv = 3'd2;
    end else if (p >= Thr3) begin
      lv = 3'd3;
    end else if (p > Thr4) begin
      lv = 3'd4;
    end else begin
      lv = LevelLow;
    end
    return lv;
  endfunction

endpackage

`default_nettype wire

@@ rtl/battery_gauge_level_indicator_core.sv @@
// a plain tick goes straight to the result register; a blink tick first runs the serial
// divider; a check tick runs the serial multiplier, a subtract step and the divider (a
// zero reading skips all three, an offset product above the numerator the divider)
// one request at a time: the next is taken only once the last has left the units, and
// it is taken while a result waits; reset: tick count, level and percent clear,
// registers to defaults
`default_nettype none

`include "assert_macros.svh"

module battery_gauge_level_indicator_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration writes
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [bgli_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [bgli_pkg::CfgDataW-1:0]     cfg_data_i,
  // tick requests
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [bgli_pkg::AdcW-1:0]         adc_sample_i,
  input  wire logic                              charging_i,
  // results
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic                                   icon_update_o,
  output logic      [bgli_pkg::IconW-1:0]        icon_code_o,
  output logic                                   buzz_o,
  output logic      [bgli_pkg::LevelW-1:0]       level_o,
  output logic      [bgli_pkg::PctW-1:0]         percent_o
);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StMul  = 5'b00010,
    StSub  = 5'b00100,
    StDiv  = 5'b01000,
    StDone = 5'b10000
  } state_e;

  state_e state_q;

  // configuration registers
  logic [bgli_pkg::CheckW-1:0] check_period_q;
  logic [bgli_pkg::BlinkW-1:0] blink_period_q;
  logic [bgli_pkg::NumW-1:0]   scale_num_q;
  logic [bgli_pkg::OffW-1:0]   scale_off_q;

  // gauge state
  logic [bgli_pkg::CheckW-1:0] tick_count_q;
  logic [bgli_pkg::LevelW-1:0] level_q;
  logic [bgli_pkg::PctW-1:0]   percent_q;

  // current request
  logic [bgli_pkg::AdcW-1:0]   adc_q;
  logic                        pct_job_q;
  logic                        blink_job_q;
  logic                        buzz_job_q;
  logic                        pct_zero_q;

  // result register
  logic                        out_valid_q;
  logic                        icon_update_q;
  logic [bgli_pkg::IconW-1:0]  icon_code_q;
  logic                        buzz_q;
  logic [bgli_pkg::LevelW-1:0] level_out_q;
  logic [bgli_pkg::PctW-1:0]   percent_out_q;

  // arithmetic units
  bgli_pkg::unit_stat_t         mul_stat;
  bgli_pkg::unit_stat_t         div_stat;
  logic [bgli_pkg::ProdW-1:0]   mul_prod;
  logic [bgli_pkg::DivW-1:0]    div_quot;
  logic [bgli_pkg::DsrW-1:0]    div_rem;
  logic                         mul_start;
  logic                         div_start;
  logic [bgli_pkg::DivW-1:0]    div_dividend;
  logic [bgli_pkg::DsrW-1:0]    div_divisor;

  logic                         accept;
  logic [bgli_pkg::CheckW-1:0]  tick_n;
  logic                         hit;
  logic                         low_mode;
  logic                         blink_on;
  logic [bgli_pkg::NumW:0]      num;
  logic                         num_neg;
  logic                         out_free;
  logic [bgli_pkg::PctW-1:0]    pct_sat;
  logic [bgli_pkg::PctW-1:0]    pct_val;
  logic [bgli_pkg::LevelW-1:0]  lv_new;
  logic                         res_upd;
  logic [bgli_pkg::IconW-1:0]   res_code;
  logic [bgli_pkg::LevelW-1:0]  res_level;
  logic [bgli_pkg::PctW-1:0]    res_pct;

  // tick decode at accept
  always_comb begin
    accept   = in_valid_i && in_ready_o;
    tick_n   = tick_count_q + 1'b1;
    hit      = (tick_n == check_period_q);
    low_mode = !charging_i && (level_q == bgli_pkg::LevelLow);
    blink_on = (blink_period_q != '0);
  end

  // numerator after the offset product
  always_comb begin
    num     = {1'b0, scale_num_q}
            - {{(bgli_pkg::NumW + 1 - bgli_pkg::ProdW){1'b0}}, mul_prod};
    num_neg = num[bgli_pkg::NumW];
  end

  // unit starts and operand select
  always_comb begin
    mul_start = accept && !low_mode && hit && (adc_sample_i != '0);
    div_start = (accept && low_mode && blink_on) || ((state_q == StSub) && !num_neg);
    if (state_q == StSub) begin
      div_dividend = num[bgli_pkg::DivW-1:0];
      div_divisor  = {adc_q, 1'b0};
    end else begin
      div_dividend = {{(bgli_pkg::DivW - bgli_pkg::CheckW){1'b0}}, tick_n};
      div_divisor  = {{(bgli_pkg::DsrW - bgli_pkg::BlinkW){1'b0}}, blink_period_q};
    end
  end

  bgli_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (scale_off_q),
    .mplier_i (adc_sample_i),
    .stat_o   (mul_stat),
    .prod_o   (mul_prod)
  );

  bgli_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .stat_o     (div_stat),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // result assembly
  always_comb begin
    out_free  = !out_valid_q || out_ready_i;
    pct_sat   = (div_quot[bgli_pkg::DivW-1:bgli_pkg::PctW] != '0) ? '1
              : div_quot[bgli_pkg::PctW-1:0];
    pct_val   = pct_zero_q ? '0 : pct_sat;
    lv_new    = bgli_pkg::level_of(pct_val);
    res_upd   = 1'b0;
    res_code  = bgli_pkg::IconNone;
    res_level = level_q;
    res_pct   = percent_q;
    if (pct_job_q) begin
      res_upd   = (lv_new != level_q);
      res_code  = res_upd ? lv_new : bgli_pkg::IconNone;
      res_level = lv_new;
      res_pct   = pct_val;
    end else if (blink_job_q) begin
      res_upd  = (div_rem == '0);
      if (res_upd) begin
        res_code = div_quot[0] ? bgli_pkg::IconLow : bgli_pkg::IconBlank;
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_period_q <= bgli_pkg::CheckPeriodRst;
      blink_period_q <= bgli_pkg::BlinkPeriodRst;
      scale_num_q    <= bgli_pkg::ScaleNumRst;
      scale_off_q    <= bgli_pkg::ScaleOffRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (bgli_pkg::cfg_idx_e'(cfg_index_i))
        bgli_pkg::CfgCheckPeriod: check_period_q <= cfg_data_i[bgli_pkg::CheckW-1:0];
        bgli_pkg::CfgBlinkPeriod: blink_period_q <= cfg_data_i[bgli_pkg::BlinkW-1:0];
        bgli_pkg::CfgScaleNum:    scale_num_q    <= cfg_data_i[bgli_pkg::NumW-1:0];
        bgli_pkg::CfgScaleOff:    scale_off_q    <= cfg_data_i[bgli_pkg::OffW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and gauge state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      tick_count_q <= '0;
      level_q      <= '0;
      percent_q    <= '0;
      pct_job_q    <= 1'b0;
      blink_job_q  <= 1'b0;
      buzz_job_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      // result valid: set on completion, cleared when taken
      if ((state_q == StDone) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (accept) begin
            tick_count_q <= hit ? '0 : tick_n;
            pct_job_q    <= !low_mode && hit;
            blink_job_q  <= low_mode && blink_on;
            buzz_job_q   <= low_mode && hit;
            if (mul_start) begin
              state_q <= StMul;
            end else if (low_mode && blink_on) begin
              state_q <= StDiv;
            end else begin
              state_q <= StDone;
            end
          end
        end
        StMul: begin
          if (mul_stat.done) begin
            state_q <= StSub;
          end
        end
        StSub: begin
          state_q <= num_neg ? StDone : StDiv;
        end
        StDiv: begin
          if (div_stat.done) begin
            state_q <= StDone;
          end
        end
        StDone: begin
          if (out_free) begin
            state_q <= StIdle;
            if (pct_job_q) begin
              level_q   <= lv_new;
              percent_q <= pct_val;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // request payload and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      adc_q      <= adc_sample_i;
      pct_zero_q <= (adc_sample_i == '0);
    end else if ((state_q == StSub) && num_neg) begin
      pct_zero_q <= 1'b1;
    end
    if ((state_q == StDone) && out_free) begin
      icon_update_q <= res_upd;
      icon_code_q   <= res_code;
      buzz_q        <= buzz_job_q;
      level_out_q   <= res_level;
      percent_out_q <= res_pct;
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign in_ready_o    = (state_q == StIdle);
  assign out_valid_o   = out_valid_q;
  assign icon_update_o = icon_update_q;
  assign icon_code_o   = icon_code_q;
  assign buzz_o        = buzz_q;
  assign level_o       = level_out_q;
  assign percent_o     = percent_out_q;

  // checks
  `BG_ASSERT_NEXT(a_one_at_a_time, in_valid_i && in_ready_o, !in_ready_o, "request overlap")
  `BG_ASSERT(a_mul_busy, (state_q == StMul) |-> mul_stat.busy, "multiplier idle in mul state")
  `BG_ASSERT(a_div_busy, (state_q == StDiv) |-> div_stat.busy, "divider idle in div state")
  `BG_ASSERT(a_buzz_low, (out_valid_o && buzz_o) |-> (level_o == bgli_pkg::LevelLow), "buzz off low")
  `BG_ASSERT(a_code_idle, (out_valid_o && !icon_update_o) |-> (icon_code_o == bgli_pkg::IconNone), "stray icon code")

endmodule

`default_nettype wire

@@ rtl/bgli_mul.sv @@
`default_nettype none

module bgli_mul (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [bgli_pkg::OffW-1:0]    mcand_i,
  input  wire logic [bgli_pkg::AdcW-1:0]    mplier_i,
  output bgli_pkg::unit_stat_t              stat_o,
  output logic      [bgli_pkg::ProdW-1:0]   prod_o
);

  localparam int CntW = $clog2(bgli_pkg::AdcW);
  localparam logic [CntW-1:0] LastCnt = CntW'(bgli_pkg::AdcW - 1);

  logic                        busy_q;
  logic [CntW-1:0]             cnt_q;
  logic [bgli_pkg::AdcW-1:0]   mpl_q;
  logic [bgli_pkg::OffW-1:0]   mcd_q;
  logic [bgli_pkg::ProdW-1:0]  acc_q;
  logic [bgli_pkg::ProdW-1:0]  acc_d;

  // shift-add, one multiplier bit per cycle, msb first
  always_comb begin
    acc_d = {acc_q[bgli_pkg::ProdW-2:0], 1'b0};
    if (mpl_q[bgli_pkg::AdcW-1]) begin
      acc_d = acc_d + {{(bgli_pkg::ProdW - bgli_pkg::OffW){1'b0}}, mcd_q};
    end
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == LastCnt) begin
        busy_q <= 1'b0;
      end
    end
  end

  // operand and accumulator shift registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mpl_q <= mplier_i;
      mcd_q <= mcand_i;
      acc_q <= '0;
    end else if (busy_q) begin
      mpl_q <= {mpl_q[bgli_pkg::AdcW-2:0], 1'b0};
      acc_q <= acc_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = busy_q && (cnt_q == LastCnt);
  assign prod_o      = acc_q;

endmodule

`default_nettype wire

@@ rtl/bgli_div.sv @@
`default_nettype none

module bgli_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [bgli_pkg::DivW-1:0]   dividend_i,
  input  wire logic [bgli_pkg::DsrW-1:0]   divisor_i,
  output bgli_pkg::unit_stat_t             stat_o,
  output logic      [bgli_pkg::DivW-1:0]   quot_o,
  output logic      [bgli_pkg::DsrW-1:0]   rem_o
);

  localparam int CntW = $clog2(bgli_pkg::DivW);
  localparam logic [CntW-1:0] LastCnt = CntW'(bgli_pkg::DivW - 1);

  logic                        busy_q;
  logic [CntW-1:0]             cnt_q;
  logic [bgli_pkg::DivW-1:0]   quot_q;
  logic [bgli_pkg::DsrW-1:0]   rem_q;
  logic [bgli_pkg::DsrW-1:0]   dsr_q;
  logic [bgli_pkg::DsrW:0]     rem_sh;
  logic [bgli_pkg::DsrW+1:0]   diff;
  logic                        ge;

  // restoring step: one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_q, quot_q[bgli_pkg::DivW-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dsr_q};
    ge     = !diff[bgli_pkg::DsrW+1];
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == LastCnt) begin
        busy_q <= 1'b0;
      end
    end
  end

  // dividend shifts out as quotient shifts in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dsr_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[bgli_pkg::DivW-2:0], ge};
      rem_q  <= ge ? diff[bgli_pkg::DsrW-1:0] : rem_sh[bgli_pkg::DsrW-1:0];
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = busy_q && (cnt_q == LastCnt);
  assign quot_o      = quot_q;
  assign rem_o       = rem_q;

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
module tb_top;
  import bgli_pkg::*;

  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned RandTicks  = 1500;
  localparam int unsigned MaxShown   = 10;

  // one tick request and one gauge indication
  typedef struct packed {
    logic [AdcW-1:0] adc;
    logic            chg;
  } tick_t;

  typedef struct packed {
    logic              upd;
    logic [IconW-1:0]  icon;
    logic              buzz;
    logic [LevelW-1:0] lvl;
    logic [PctW-1:0]   pct;
  } gauge_ind_t;

  logic clk;
  logic rst_n;

  // dut-facing signals
  logic                cfg_valid;
  cfg_idx_e            cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic                in_valid;
  logic [AdcW-1:0]     adc_sample;
  logic                charging;
  logic                out_ready;
  logic                cfg_ready_o;
  logic                in_ready_o;
  logic                out_valid_o;
  logic                icon_update_o;
  logic [IconW-1:0]    icon_code_o;
  logic                buzz_o;
  logic [LevelW-1:0]   level_o;
  logic [PctW-1:0]     percent_o;

  // predictor copy of the registers and the gauge state
  logic [CheckW-1:0]   chk_period;
  logic [BlinkW-1:0]   blink_period;
  logic [NumW-1:0]     scale_num;
  logic [OffW-1:0]     scale_off;
  logic [CheckW-1:0]   tick_cnt;
  logic [LevelW-1:0]   gauge_lvl;
  logic [PctW-1:0]     gauge_pct;

  // pending ticks and indications still owed by the dut
  tick_t       tick_q[$];
  gauge_ind_t  ind_due_q[$];
  int unsigned ticks_queued;
  int unsigned ticks_taken;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned bad_cnt;
  int unsigned res_cnt;
  int unsigned cycle_cnt;
  logic        no_idle;

  battery_gauge_level_indicator_core u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .adc_sample_i (adc_sample),
    .charging_i   (charging),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .icon_update_o(icon_update_o),
    .icon_code_o  (icon_code_o),
    .buzz_o       (buzz_o),
    .level_o      (level_o),
    .percent_o    (percent_o)
  );

  // percent from one reading, exact integer math with saturation
  function automatic logic [PctW-1:0] percent_of(input logic [AdcW-1:0] adc);
    longint num;
    longint quo;
    if (adc == '0) return '0;
    num = longint'(scale_num) - longint'(scale_off) * longint'(adc);
    if (num < 0) return '0;
    quo = num / (2 * longint'(adc));
    if (quo > 255) return 8'hFF;
    return quo[PctW-1:0];
  endfunction

  // percent to level band, 0 full .. 5 low
  function automatic logic [LevelW-1:0] band_of(input logic [PctW-1:0] p);
    logic [LevelW-1:0] b;
    b = LevelLow;
    if (p > Thr4) b = 3'd4;
    if (p >= Thr3) b = 3'd3;
    if (p >= Thr2) b = 3'd2;
    if (p >= Thr1) b = 3'd1;
    if (p >= Thr0) b = 3'd0;
    return b;
  endfunction

  // advance the gauge by one tick and return the indication it owes
  function automatic gauge_ind_t advance_gauge(input logic [AdcW-1:0] adc, input logic chg);
    gauge_ind_t        r;
    logic [LevelW-1:0] nl;
    logic [CheckW-1:0] phase;
    r = '0;
    tick_cnt = tick_cnt + 16'd1;
    if (chg || gauge_lvl != LevelLow) begin
      if (tick_cnt == chk_period) begin
        tick_cnt = '0;
        gauge_pct = percent_of(adc);
        nl = band_of(gauge_pct);
        if (nl != gauge_lvl) begin
          gauge_lvl = nl;
          r.upd = 1'b1;
          r.icon = nl;
        end
      end
    end else begin
      // low battery on its own: blink the icon, buzz at the check period
      if (blink_period != '0 && (tick_cnt % {8'd0, blink_period}) == '0) begin
        phase = tick_cnt / {8'd0, blink_period};
        r.upd = 1'b1;
        r.icon = phase[0] ? IconLow : IconBlank;
      end
      if (tick_cnt == chk_period) begin
        tick_cnt = '0;
        r.buzz = 1'b1;
      end
    end
    r.lvl = gauge_lvl;
    r.pct = gauge_pct;
    return r;
  endfunction

  // idle length: mostly short, sometimes long
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [AdcW-1:0] pick_adc();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 15) return 8'hFF;
    if (r < 30) return 8'($urandom_range(1, 30));
    return 8'($urandom_range(0, 255));
  endfunction

  // mostly a period just ahead of the current count so that checks happen
  function automatic logic [CheckW-1:0] pick_check();
    int unsigned r;
    int unsigned ahead;
    r = $urandom_range(0, 99);
    ahead = tick_cnt + $urandom_range(1, 12);
    if (r < 5) return 16'hFFFF;
    if (r < 10) return '0;
    if (r < 20 || ahead > 16'hFFFF) return 16'd1;
    return ahead[CheckW-1:0];
  endfunction

  function automatic logic [BlinkW-1:0] pick_blink();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20) return 8'd1;
    if (r < 30) return 8'hFF;
    if (r < 40) return '0;
    if (r < 80) return 8'($urandom_range(2, 6));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [NumW-1:0] pick_num();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return ScaleNumRst;
    if (r < 60) return '0;
    if (r < 70) return 20'hFFFFF;
    if (r < 90) return 20'($urandom_range(50000, 110000));
    return 20'($urandom_range(0, 20'hFFFFF));
  endfunction

  function automatic logic [OffW-1:0] pick_off();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return ScaleOffRst;
    if (r < 60) return '0;
    if (r < 70) return 10'h3FF;
    if (r < 90) return 10'($urandom_range(200, 450));
    return 10'($urandom_range(0, 10'h3FF));
  endfunction

  function automatic void queue_tick(input logic [AdcW-1:0] adc, input logic chg);
    tick_t t;
    t.adc = adc;
    t.chg = chg;
    tick_q.push_back(t);
    ticks_queued++;
  endfunction

  // one register write; random junk above the register width half the time
  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    logic [CfgDataW-1:0] data;
    data = val;
    if ($urandom_range(0, 1) == 1) begin
      case (idx)
        CfgCheckPeriod: data[CfgDataW-1:CheckW] = (CfgDataW - CheckW)'($urandom);
        CfgBlinkPeriod: data[CfgDataW-1:BlinkW] = (CfgDataW - BlinkW)'($urandom);
        CfgScaleOff:    data[CfgDataW-1:OffW] = (CfgDataW - OffW)'($urandom);
        default: ;
      endcase
    end
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    case (idx)
      CfgCheckPeriod: chk_period = data[CheckW-1:0];
      CfgBlinkPeriod: blink_period = data[BlinkW-1:0];
      CfgScaleNum:    scale_num = data[NumW-1:0];
      CfgScaleOff:    scale_off = data[OffW-1:0];
      default: ;
    endcase
  endtask

  // wait until every queued tick is taken and every indication is back
  task automatic drain();
    while (ticks_taken != ticks_queued || ind_due_q.size() != 0) @(posedge clk);
  endtask

  // clock and known input levels from time zero
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CfgCheckPeriod;
    cfg_data = '0;
    in_valid = 1'b0;
    adc_sample = '0;
    charging = 1'b0;
    out_ready = 1'b0;
    forever #2 clk = ~clk;
  end

  // reset pulse
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("FAIL battery_gauge_level_indicator_core");
      $finish;
    end
  end

  // tick request driver
  always @(posedge clk) begin : tick_driver
    tick_t nxt;
    if (rst_n) begin
      if (in_valid && in_ready_o) begin
        ind_due_q.push_back(advance_gauge(adc_sample, charging));
        ticks_taken++;
      end
      if (!in_valid || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (tick_q.size() != 0) begin
          nxt = tick_q.pop_front();
          in_valid <= 1'b1;
          adc_sample <= nxt.adc;
          charging <= nxt.chg;
          gap_left = (no_idle || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // indication monitor and checker
  always @(posedge clk) begin : ind_monitor
    gauge_ind_t got;
    gauge_ind_t want;
    if (rst_n) begin
      if (out_valid_o && out_ready) begin
        got = '{icon_update_o, icon_code_o, buzz_o, level_o, percent_o};
        res_cnt++;
        if (ind_due_q.size() == 0) begin
          bad_cnt++;
          if (bad_cnt <= MaxShown)
            $display("result %0d unexpected: upd=%0d icon=%0d buzz=%0d lvl=%0d pct=%0d",
                     res_cnt, got.upd, got.icon, got.buzz, got.lvl, got.pct);
        end else begin
          want = ind_due_q.pop_front();
          if (got.upd !== want.upd || got.icon !== want.icon || got.buzz !== want.buzz ||
              got.lvl !== want.lvl || got.pct !== want.pct) begin
            bad_cnt++;
            if (bad_cnt <= MaxShown) begin
              $display("result %0d mismatch: exp upd=%0d icon=%0d buzz=%0d lvl=%0d pct=%0d",
                       res_cnt, want.upd, want.icon, want.buzz, want.lvl, want.pct);
              $display("  got upd=%0d icon=%0d buzz=%0d lvl=%0d pct=%0d",
                       got.upd, got.icon, got.buzz, got.lvl, got.pct);
            end
          end
        end
      end
      // receiver back-pressure
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 9) < 3) begin
        stall_left = pick_gap() - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // stimulus
  initial begin : stim
    int unsigned rand_sent;
    int unsigned n;
    int unsigned chg_bias;
    chk_period = CheckPeriodRst;
    blink_period = BlinkPeriodRst;
    scale_num = ScaleNumRst;
    scale_off = ScaleOffRst;
    tick_cnt = '0;
    gauge_lvl = '0;
    gauge_pct = '0;
    ticks_queued = 0;
    ticks_taken = 0;
    gap_left = 0;
    stall_left = 0;
    bad_cnt = 0;
    res_cnt = 0;
    cycle_cnt = 0;
    no_idle = 1'b0;
    rand_sent = 0;
    while (!rst_n) @(posedge clk);

    // register defaults, no check due yet
    queue_tick(8'd0, 1'b0);
    queue_tick(8'hFF, 1'b0);
    drain();

    // zero check period: nothing happens before the counter wraps
    write_reg(CfgCheckPeriod, 20'd0);
    queue_tick(8'd7, 1'b0);
    queue_tick(8'd9, 1'b1);
    drain();

    // period lowered below the count: no check until the counter wraps
    write_reg(CfgCheckPeriod, 20'd2);
    no_idle = 1'b1;
    repeat (20) queue_tick(pick_adc(), 1'b1);
    drain();
    no_idle = 1'b0;

    // one check right away brings the count back to zero
    write_reg(CfgCheckPeriod, 20'(tick_cnt + 16'd1));
    queue_tick(pick_adc(), 1'b1);
    drain();

    // check on every tick, walk through the levels and saturation
    write_reg(CfgCheckPeriod, 20'd1);
    write_reg(CfgBlinkPeriod, 20'd1);
    write_reg(CfgScaleNum, 20'(ScaleNumRst));
    write_reg(CfgScaleOff, 20'(ScaleOffRst));
    queue_tick(8'd0, 1'b1);
    queue_tick(8'd1, 1'b1);
    queue_tick(8'hFF, 1'b1);
    queue_tick(8'd170, 1'b1);
    queue_tick(8'd180, 1'b1);
    queue_tick(8'd200, 1'b1);
    queue_tick(8'd220, 1'b1);
    queue_tick(8'd240, 1'b1);
    queue_tick(8'd240, 1'b0);
    drain();

    // largest scale values, then the longest check period
    write_reg(CfgBlinkPeriod, 20'hFF);
    write_reg(CfgScaleNum, 20'hFFFFF);
    write_reg(CfgScaleOff, 20'h3FF);
    queue_tick(8'd1, 1'b1);
    queue_tick(8'hFF, 1'b1);
    queue_tick(8'd128, 1'b1);
    drain();
    write_reg(CfgCheckPeriod, 20'hFFFF);
    queue_tick(8'd0, 1'b0);
    drain();

    // zero scale gives percent zero; zero blink period means buzz only
    write_reg(CfgCheckPeriod, 20'(tick_cnt + 16'd3));
    write_reg(CfgBlinkPeriod, 20'd0);
    write_reg(CfgScaleNum, 20'd0);
    write_reg(CfgScaleOff, 20'd0);
    repeat (3) queue_tick(8'd77, 1'b1);
    drain();
    repeat (6) queue_tick(8'd200, 1'b0);
    drain();

    // random phases, each with its own register setting and charge mix
    while (rand_sent < RandTicks) begin
      if ($urandom_range(0, 3) != 0) write_reg(CfgCheckPeriod, 20'(pick_check()));
      if ($urandom_range(0, 3) != 0) write_reg(CfgBlinkPeriod, 20'(pick_blink()));
      if ($urandom_range(0, 3) != 0) write_reg(CfgScaleNum, pick_num());
      if ($urandom_range(0, 3) != 0) write_reg(CfgScaleOff, 20'(pick_off()));
      no_idle = ($urandom_range(0, 4) == 0);
      chg_bias = $urandom_range(0, 100);
      n = $urandom_range(40, 160);
      repeat (n) queue_tick(pick_adc(), $urandom_range(0, 99) < chg_bias);
      rand_sent += n;
      drain();
    end
    no_idle = 1'b0;

    repeat (40) @(posedge clk);
    if (bad_cnt == 0 && ind_due_q.size() == 0) begin
      $display("PASS battery_gauge_level_indicator_core");
    end else begin
      $display("FAIL battery_gauge_level_indicator_core");
    end
    $finish;
  end

endmodule
